[src/aae_pkg.sv]
package aae_pkg;

  localparam int CODE_BITS = 16;
  localparam logic [15:0] QTR1 = 16'h4000;
  localparam logic [15:0] HALF = 16'h8000;
  localparam logic [15:0] QTR3 = 16'hC000;
  localparam logic [15:0] TOP_VAL = 16'hFFFF;

  localparam int NSYM = 258;
  localparam logic [8:0] EOF_SYM = 9'd257;
  localparam logic [8:0] LAST_IDX = 9'd257;

  // Result buffer for the bytes of one item.
  localparam int MAX_RES = 52;
  localparam int FIFO_AW = 6;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  // Dividend is a 17-bit span times a 14-bit count.
  localparam int DIV_W = 31;
  localparam int DIVISOR_W = 14;

  typedef enum logic [5:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_T0,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_MUL1,
    ST_DIVS1,
    ST_DIVW1,
    ST_MUL2,
    ST_DIVS2,
    ST_DIVW2,
    ST_RENORM,
    ST_FOLLOW,
    ST_FLUSH,
    ST_FINAL,
    ST_DRAIN_RD,
    ST_DRAIN_LD,
    ST_DRAIN_WAIT,
    ST_RS_RD,
    ST_RS_WR,
    ST_FIND0,
    ST_FINDC,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_SW0,
    ST_SW1,
    ST_SW2,
    ST_SW3,
    ST_SW4,
    ST_INC,
    ST_CUM_RD,
    ST_CUM_WR
  } state_t;

endpackage

[src/aae_in_if.sv]
interface aae_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

[src/aae_out_if.sv]
interface aae_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_of_run;
  logic       stream_done;
  logic       follow_saturated;

  modport source (output valid, output code_byte, output last_of_run, output stream_done,
                  output follow_saturated, input ready);
  modport sink (input valid, input code_byte, input last_of_run, input stream_done,
                input follow_saturated, output ready);
endinterface

[src/aae_div.sv]
module aae_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [aae_pkg::DIV_W-1:0]           dividend,
  input  logic [aae_pkg::DIVISOR_W-1:0]       divisor,
  output logic                                done,
  output logic [aae_pkg::DIV_W-1:0]           quotient
);

  logic                              busy;
  logic [4:0]                        cnt;
  logic [aae_pkg::DIVISOR_W-1:0]     rem;
  logic [aae_pkg::DIVISOR_W-1:0]     dvs;
  logic [aae_pkg::DIV_W-1:0]         quo;
  logic [aae_pkg::DIVISOR_W:0]       trial;
  logic                              ge;

  // One restoring step per cycle: the dividend shifts out at the top while
  // quotient bits shift in at the bottom.
  always_comb begin
    trial = {rem, quo[aae_pkg::DIV_W-1]};
    ge = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvs  <= divisor;
        quo  <= dividend;
      end else if (busy) begin
        rem <= ge ? aae_pkg::DIVISOR_W'(trial - {1'b0, dvs})
                  : trial[aae_pkg::DIVISOR_W-1:0];
        quo <= {quo[aae_pkg::DIV_W-2:0], ge};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(aae_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

[src/adaptive_arithmetic_encoder.sv]
// Adaptive order-0 arithmetic encoder; the next input beat is taken once the model update ends.
// The range is narrowed by two serial divisions, one after the other; then E1/E2 steps, E3
// steps and follow bits renormalize it, and each result byte waits until the sink takes it.
// Model update: each equal-count step and each cumulative entry takes a registered memory read
// and a write; a rescale pass over all entries runs first once the total reaches MAX_TOTAL.
// Reset, and every end item, run a pass over all 258 entries that reloads the model memories.
module adaptive_arithmetic_encoder #(
  parameter int MAX_TOTAL  = 16383,
  parameter int FOLLOW_CAP = 192
) (
  input  logic      clk,
  input  logic      rst,
  aae_in_if.sink    in_ch,
  aae_out_if.source out_ch
);

  aae_pkg::state_t state, state_next;

  // Model memories and the result buffer.
  logic [13:0] sc_mem  [0:aae_pkg::NSYM-1];
  logic [13:0] cum_mem [0:aae_pkg::NSYM-1];
  logic [7:0]  stb_mem [0:aae_pkg::NSYM-1];
  logic [8:0]  bts_mem [0:255];
  logic [8:0]  fifo_mem [0:aae_pkg::FIFO_DEPTH-1];

  logic [8:0]  sc_raddr, sc_waddr, cum_raddr, cum_waddr, stb_raddr, stb_waddr;
  logic [7:0]  bts_raddr, bts_waddr;
  logic [13:0] sc_rdata, sc_wdata, cum_rdata, cum_wdata;
  logic [7:0]  stb_rdata, stb_wdata;
  logic [8:0]  bts_rdata, bts_wdata;
  logic        sc_we, cum_we, stb_we, bts_we;
  logic [aae_pkg::FIFO_AW-1:0] fifo_raddr;
  logic [8:0]  fifo_rdata, fifo_wdata;
  logic        fifo_we;

  // Coder registers.
  logic [15:0] low, low_next, high, high_next;
  logic [7:0]  pending, pending_next;
  logic [7:0]  shift_buf, shift_buf_next;
  logic [3:0]  bits_left, bits_left_next;
  logic        ovf, ovf_next;
  logic [8:0]  sym, sym_next, idx, idx_next, k, k_next;
  logic [13:0] tot, tot_next, cup, cup_next, clo, clo_next, cval, cval_next;
  logic [13:0] run, run_next;
  logic [7:0]  bi, bi_next, bs, bs_next;
  logic [30:0] qa, qa_next, prod, prod_next;
  logic        cur_bit, cur_bit_next, eos_item, eos_item_next, flush_phase, flush_phase_next;
  logic [aae_pkg::FIFO_AW-1:0] fcnt, fcnt_next, dk, dk_next;
  logic [7:0]  o_byte, o_byte_next;
  logic        o_last, o_last_next, o_done, o_done_next, o_sat, o_sat_next;

  logic        pb_en, pb_bit, af_en, push_final;
  logic [3:0]  bl_dec;
  logic [16:0] span;
  logic [13:0] mul_op, divisor, half_cnt;
  logic [8:0]  sym_map;
  logic        div_start, div_done;
  logic [30:0] quot;
  logic        in_acc;

  aae_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quot)
  );

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == aae_pkg::ST_IDLE);
  assign out_ch.valid = (state == aae_pkg::ST_DRAIN_WAIT);
  assign out_ch.code_byte = o_byte;
  assign out_ch.last_of_run = o_last;
  assign out_ch.stream_done = o_done;
  assign out_ch.follow_saturated = o_sat;

  assign span = {1'b0, high} - {1'b0, low} + 17'd1;
  assign divisor = (tot == 14'd0) ? 14'd1 : tot;
  assign half_cnt = 14'(({1'b0, sc_rdata} + 15'd1) >> 1);
  assign sym_map = (bts_rdata == 9'd0 || bts_rdata > 9'd256) ? 9'd1 : bts_rdata;
  assign bl_dec = bits_left - 4'd1;

  always_comb begin
    state_next = state;
    low_next = low;
    high_next = high;
    pending_next = pending;
    shift_buf_next = shift_buf;
    bits_left_next = bits_left;
    ovf_next = ovf;
    sym_next = sym;
    idx_next = idx;
    k_next = k;
    tot_next = tot;
    cup_next = cup;
    clo_next = clo;
    cval_next = cval;
    run_next = run;
    bi_next = bi;
    bs_next = bs;
    qa_next = qa;
    prod_next = prod;
    cur_bit_next = cur_bit;
    eos_item_next = eos_item;
    flush_phase_next = flush_phase;
    fcnt_next = fcnt;
    dk_next = dk;
    o_byte_next = o_byte;
    o_last_next = o_last;
    o_done_next = o_done;
    o_sat_next = o_sat;

    sc_raddr = idx;
    cum_raddr = k;
    stb_raddr = idx;
    bts_raddr = in_ch.data_byte;
    fifo_raddr = dk;
    sc_we = 1'b0;
    sc_waddr = k;
    sc_wdata = 14'd1;
    cum_we = 1'b0;
    cum_waddr = k;
    cum_wdata = cum_rdata + 14'd1;
    stb_we = 1'b0;
    stb_waddr = idx;
    stb_wdata = bs;
    bts_we = 1'b0;
    bts_waddr = bi;
    bts_wdata = sym;
    fifo_we = 1'b0;
    fifo_wdata = {1'b0, shift_buf};
    div_start = 1'b0;
    mul_op = cup;
    pb_en = 1'b0;
    pb_bit = 1'b0;
    af_en = 1'b0;
    push_final = 1'b0;

    case (state)
      aae_pkg::ST_CLEAR: begin
        sc_we = 1'b1;
        sc_wdata = (k == 9'd0) ? 14'd0 : 14'd1;
        cum_we = 1'b1;
        cum_wdata = 14'(aae_pkg::LAST_IDX - k);
        stb_we = 1'b1;
        stb_waddr = k;
        stb_wdata = 8'(k - 9'd1);
        bts_we = (k < 9'd256);
        bts_waddr = k[7:0];
        bts_wdata = k + 9'd1;
        low_next = '0;
        high_next = aae_pkg::TOP_VAL;
        pending_next = '0;
        shift_buf_next = '0;
        bits_left_next = 4'd8;
        ovf_next = 1'b0;
        if (k == aae_pkg::LAST_IDX) begin
          state_next = aae_pkg::ST_IDLE;
        end else begin
          k_next = k + 9'd1;
        end
      end
      aae_pkg::ST_IDLE: begin
        if (in_acc) begin
          fcnt_next = '0;
          dk_next = '0;
          flush_phase_next = 1'b0;
          eos_item_next = in_ch.end_of_stream;
          if (in_ch.end_of_stream) begin
            sym_next = aae_pkg::EOF_SYM;
            state_next = aae_pkg::ST_T0;
          end else begin
            state_next = aae_pkg::ST_MAP;
          end
        end
      end
      aae_pkg::ST_MAP: begin
        sym_next = sym_map;
        state_next = aae_pkg::ST_T0;
      end
      aae_pkg::ST_T0: begin
        cum_raddr = 9'd0;
        state_next = aae_pkg::ST_T1;
      end
      aae_pkg::ST_T1: begin
        tot_next = cum_rdata;
        cum_raddr = sym - 9'd1;
        state_next = aae_pkg::ST_T2;
      end
      aae_pkg::ST_T2: begin
        cup_next = cum_rdata;
        cum_raddr = sym;
        state_next = aae_pkg::ST_T3;
      end
      aae_pkg::ST_T3: begin
        clo_next = cum_rdata;
        state_next = aae_pkg::ST_MUL1;
      end
      aae_pkg::ST_MUL1: begin
        mul_op = cup;
        prod_next = {14'd0, span} * {17'd0, mul_op};
        state_next = aae_pkg::ST_DIVS1;
      end
      aae_pkg::ST_DIVS1: begin
        div_start = 1'b1;
        state_next = aae_pkg::ST_DIVW1;
      end
      aae_pkg::ST_DIVW1: begin
        if (div_done) begin
          qa_next = quot;
          state_next = aae_pkg::ST_MUL2;
        end
      end
      aae_pkg::ST_MUL2: begin
        mul_op = clo;
        prod_next = {14'd0, span} * {17'd0, mul_op};
        state_next = aae_pkg::ST_DIVS2;
      end
      aae_pkg::ST_DIVS2: begin
        div_start = 1'b1;
        state_next = aae_pkg::ST_DIVW2;
      end
      aae_pkg::ST_DIVW2: begin
        if (div_done) begin
          high_next = low + qa[15:0] - 16'd1;
          low_next = low + quot[15:0];
          state_next = aae_pkg::ST_RENORM;
        end
      end
      aae_pkg::ST_RENORM: begin
        if (high < aae_pkg::HALF) begin
          pb_en = 1'b1;
          pb_bit = 1'b0;
          cur_bit_next = 1'b0;
          low_next = {low[14:0], 1'b0};
          high_next = {high[14:0], 1'b1};
          state_next = aae_pkg::ST_FOLLOW;
        end else if (low >= aae_pkg::HALF) begin
          pb_en = 1'b1;
          pb_bit = 1'b1;
          cur_bit_next = 1'b1;
          low_next = {low[14:0], 1'b0};
          high_next = {high[14:0], 1'b1};
          state_next = aae_pkg::ST_FOLLOW;
        end else if (low >= aae_pkg::QTR1 && high < aae_pkg::QTR3) begin
          af_en = 1'b1;
          low_next = {low[14:0] - aae_pkg::QTR1[14:0], 1'b0};
          high_next = {high[14:0] - aae_pkg::QTR1[14:0], 1'b1};
        end else if (eos_item) begin
          state_next = aae_pkg::ST_FLUSH;
        end else begin
          dk_next = '0;
          state_next = aae_pkg::ST_DRAIN_RD;
        end
      end
      aae_pkg::ST_FOLLOW: begin
        if (pending != 8'd0) begin
          pb_en = 1'b1;
          pb_bit = !cur_bit;
          pending_next = pending - 8'd1;
        end else if (flush_phase) begin
          state_next = aae_pkg::ST_FINAL;
        end else begin
          state_next = aae_pkg::ST_RENORM;
        end
      end
      aae_pkg::ST_FLUSH: begin
        af_en = 1'b1;
        pb_en = 1'b1;
        pb_bit = (low >= aae_pkg::QTR1);
        cur_bit_next = pb_bit;
        flush_phase_next = 1'b1;
        state_next = aae_pkg::ST_FOLLOW;
      end
      aae_pkg::ST_FINAL: begin
        push_final = 1'b1;
        dk_next = '0;
        state_next = aae_pkg::ST_DRAIN_RD;
      end
      aae_pkg::ST_DRAIN_RD: begin
        if (dk == fcnt) begin
          if (eos_item) begin
            k_next = '0;
            state_next = aae_pkg::ST_CLEAR;
          end else if (tot >= 14'(MAX_TOTAL)) begin
            k_next = aae_pkg::LAST_IDX;
            run_next = '0;
            state_next = aae_pkg::ST_RS_RD;
          end else begin
            state_next = aae_pkg::ST_FIND0;
          end
        end else begin
          state_next = aae_pkg::ST_DRAIN_LD;
        end
      end
      aae_pkg::ST_DRAIN_LD: begin
        o_byte_next = fifo_rdata[7:0];
        o_done_next = fifo_rdata[8];
        o_last_next = (dk + 1'b1 == fcnt);
        o_sat_next = ovf;
        state_next = aae_pkg::ST_DRAIN_WAIT;
      end
      aae_pkg::ST_DRAIN_WAIT: begin
        if (out_ch.ready) begin
          dk_next = dk + 1'b1;
          state_next = aae_pkg::ST_DRAIN_RD;
        end
      end
      aae_pkg::ST_RS_RD: begin
        sc_raddr = k;
        state_next = aae_pkg::ST_RS_WR;
      end
      aae_pkg::ST_RS_WR: begin
        sc_we = 1'b1;
        sc_wdata = half_cnt;
        cum_we = 1'b1;
        cum_wdata = run;
        run_next = run + half_cnt;
        if (k == 9'd0) begin
          state_next = aae_pkg::ST_FIND0;
        end else begin
          k_next = k - 9'd1;
          state_next = aae_pkg::ST_RS_RD;
        end
      end
      aae_pkg::ST_FIND0: begin
        sc_raddr = sym;
        idx_next = sym;
        state_next = aae_pkg::ST_FINDC;
      end
      aae_pkg::ST_FINDC: begin
        cval_next = sc_rdata;
        state_next = aae_pkg::ST_FIND_RD;
      end
      aae_pkg::ST_FIND_RD: begin
        sc_raddr = idx - 9'd1;
        state_next = (idx > 9'd1) ? aae_pkg::ST_FIND_CMP : aae_pkg::ST_SW0;
      end
      aae_pkg::ST_FIND_CMP: begin
        if (sc_rdata == cval) begin
          idx_next = idx - 9'd1;
          state_next = aae_pkg::ST_FIND_RD;
        end else begin
          state_next = aae_pkg::ST_SW0;
        end
      end
      aae_pkg::ST_SW0: begin
        stb_raddr = idx;
        state_next = (idx < sym) ? aae_pkg::ST_SW1 : aae_pkg::ST_INC;
      end
      aae_pkg::ST_SW1: begin
        bi_next = stb_rdata;
        stb_raddr = sym;
        state_next = aae_pkg::ST_SW2;
      end
      aae_pkg::ST_SW2: begin
        bs_next = stb_rdata;
        state_next = aae_pkg::ST_SW3;
      end
      aae_pkg::ST_SW3: begin
        stb_we = 1'b1;
        stb_waddr = idx;
        stb_wdata = bs;
        bts_we = 1'b1;
        bts_waddr = bi;
        bts_wdata = sym;
        state_next = aae_pkg::ST_SW4;
      end
      aae_pkg::ST_SW4: begin
        stb_we = 1'b1;
        stb_waddr = sym;
        stb_wdata = bi;
        bts_we = 1'b1;
        bts_waddr = bs;
        bts_wdata = idx;
        state_next = aae_pkg::ST_INC;
      end
      aae_pkg::ST_INC: begin
        sc_we = 1'b1;
        sc_waddr = idx;
        sc_wdata = cval + 14'd1;
        k_next = idx - 9'd1;
        state_next = aae_pkg::ST_CUM_RD;
      end
      aae_pkg::ST_CUM_RD: begin
        cum_raddr = k;
        state_next = aae_pkg::ST_CUM_WR;
      end
      aae_pkg::ST_CUM_WR: begin
        cum_we = 1'b1;
        cum_wdata = cum_rdata + 14'd1;
        if (k == 9'd0) begin
          state_next = aae_pkg::ST_IDLE;
        end else begin
          k_next = k - 9'd1;
          state_next = aae_pkg::ST_CUM_RD;
        end
      end
      default: begin
        k_next = '0;
        state_next = aae_pkg::ST_CLEAR;
      end
    endcase

    if (af_en) begin
      if (pending < 8'(FOLLOW_CAP)) begin
        pending_next = pending + 8'd1;
      end else begin
        ovf_next = 1'b1;
      end
    end

    if (pb_en) begin
      shift_buf_next = {pb_bit, shift_buf[7:1]};
      bits_left_next = bl_dec;
      if (bl_dec == 4'd0) begin
        bits_left_next = 4'd8;
        fifo_wdata = {1'b0, pb_bit, shift_buf[7:1]};
        if (fcnt < aae_pkg::FIFO_AW'(aae_pkg::MAX_RES)) begin
          fifo_we = 1'b1;
          fcnt_next = fcnt + 1'b1;
        end
      end
    end

    // The final byte keeps only the bits that were shifted in, zero-padded above.
    if (push_final) begin
      fifo_wdata = {1'b1, shift_buf >> bits_left};
      if (fcnt < aae_pkg::FIFO_AW'(aae_pkg::MAX_RES)) begin
        fifo_we = 1'b1;
        fcnt_next = fcnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sc_rdata <= sc_mem[sc_raddr];
    cum_rdata <= cum_mem[cum_raddr];
    stb_rdata <= stb_mem[stb_raddr];
    bts_rdata <= bts_mem[bts_raddr];
    fifo_rdata <= fifo_mem[fifo_raddr];
    if (sc_we) begin
      sc_mem[sc_waddr] <= sc_wdata;
    end
    if (cum_we) begin
      cum_mem[cum_waddr] <= cum_wdata;
    end
    if (stb_we) begin
      stb_mem[stb_waddr] <= stb_wdata;
    end
    if (bts_we) begin
      bts_mem[bts_waddr] <= bts_wdata;
    end
    if (fifo_we) begin
      fifo_mem[fcnt] <= fifo_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aae_pkg::ST_CLEAR;
      k <= '0;
      low <= '0;
      high <= aae_pkg::TOP_VAL;
      pending <= '0;
      shift_buf <= '0;
      bits_left <= 4'd8;
      ovf <= 1'b0;
      fcnt <= '0;
      dk <= '0;
      eos_item <= 1'b0;
      flush_phase <= 1'b0;
    end else begin
      state <= state_next;
      k <= k_next;
      low <= low_next;
      high <= high_next;
      pending <= pending_next;
      shift_buf <= shift_buf_next;
      bits_left <= bits_left_next;
      ovf <= ovf_next;
      fcnt <= fcnt_next;
      dk <= dk_next;
      eos_item <= eos_item_next;
      flush_phase <= flush_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    sym <= sym_next;
    idx <= idx_next;
    tot <= tot_next;
    cup <= cup_next;
    clo <= clo_next;
    cval <= cval_next;
    run <= run_next;
    bi <= bi_next;
    bs <= bs_next;
    qa <= qa_next;
    prod <= prod_next;
    cur_bit <= cur_bit_next;
    o_byte <= o_byte_next;
    o_last <= o_last_next;
    o_done <= o_done_next;
    o_sat <= o_sat_next;
  end

  a_bits_left: assert property (@(posedge clk) disable iff (rst)
    bits_left >= 4'd1 && bits_left <= 4'd8)
    else $error("bit counter left its range");

  a_pending_cap: assert property (@(posedge clk) disable iff (rst)
    pending <= 8'(FOLLOW_CAP))
    else $error("follow count above its cap");

  a_fifo_fill: assert property (@(posedge clk) disable iff (rst)
    fcnt <= aae_pkg::FIFO_AW'(aae_pkg::MAX_RES) && dk <= fcnt)
    else $error("result buffer count out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != aae_pkg::ST_IDLE)
    else $error("input beat accepted without starting work");

endmodule
